[src/rc5_ir_pkg.sv]
package rc5_ir_pkg;

    // Frame geometry
    localparam int FRAME_BITS = 12;
    localparam int POS_W      = (FRAME_BITS < 15) ? 4 : 5;
    localparam logic [POS_W-1:0] IDLE_POS   = POS_W'((FRAME_BITS < 15) ? 15 : 31);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BITS);

    // Visible frame fields always come from bits 11..0
    localparam int VIS_BITS = 12;
    localparam int EXT_W    = (FRAME_BITS > VIS_BITS) ? FRAME_BITS : VIS_BITS;

    localparam int WAIT_W  = 16;
    localparam int CODE_W  = 6;
    localparam int ADDR_W  = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_INITIAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_HALF_BIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_FULL_BIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_AFTER_FRAME = 2'd3;

    // Reset values of the wait registers
    localparam logic [WAIT_W-1:0] RST_WAIT_INITIAL     = 16'd20;
    localparam logic [WAIT_W-1:0] RST_WAIT_HALF_BIT    = 16'd4;
    localparam logic [WAIT_W-1:0] RST_WAIT_FULL_BIT    = 16'd8;
    localparam logic [WAIT_W-1:0] RST_WAIT_AFTER_FRAME = 16'd20;

    // Input item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_initial;
        logic [WAIT_W-1:0] wait_half_bit;
        logic [WAIT_W-1:0] wait_full_bit;
        logic [WAIT_W-1:0] wait_after_frame;
    } cfg_t;

    typedef struct packed {
        logic              event_valid;
        logic [CODE_W-1:0] event_code;
        logic              new_data;
        logic              toggle_bit;
        logic [ADDR_W-1:0] device_address;
        logic [CODE_W-1:0] data_bits;
    } res_t;

    // Bits 11..0 of a stored frame, zero-extended for short frames
    function automatic logic [VIS_BITS-1:0] visible_bits(input logic [FRAME_BITS-1:0] frame);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(frame);
        return ext[VIS_BITS-1:0];
    endfunction

endpackage

[src/rc5_ir_cfg.sv]
module rc5_ir_cfg
    import rc5_ir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WAIT_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Write one wait register per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wait_initial     <= RST_WAIT_INITIAL;
            cfg_reg.wait_half_bit    <= RST_WAIT_HALF_BIT;
            cfg_reg.wait_full_bit    <= RST_WAIT_FULL_BIT;
            cfg_reg.wait_after_frame <= RST_WAIT_AFTER_FRAME;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WAIT_INITIAL:     cfg_reg.wait_initial     <= cfg_data;
                REG_WAIT_HALF_BIT:    cfg_reg.wait_half_bit    <= cfg_data;
                REG_WAIT_FULL_BIT:    cfg_reg.wait_full_bit    <= cfg_data;
                REG_WAIT_AFTER_FRAME: cfg_reg.wait_after_frame <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/rc5_ir_core.sv]
module rc5_ir_core
    import rc5_ir_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic step,
    input  logic command,
    input  logic ir_sample,
    input  logic start_edge,
    input  cfg_t cfg,
    output res_t res
);

    logic                  armed_reg,   armed_next;
    logic [WAIT_W-1:0]     wait_reg,    wait_next;
    logic [POS_W-1:0]      pos_reg,     pos_next;
    logic [FRAME_BITS-1:0] shift_reg,   shift_next;
    logic [FRAME_BITS-1:0] stored_reg,  stored_next;
    logic                  unread_reg,  unread_next;
    logic                  ev;
    logic                  armed_now;
    logic [VIS_BITS-1:0]   vis;

    // Next frame state for the item in the input register
    always_comb begin
        armed_next  = armed_reg;
        wait_next   = wait_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        stored_next = stored_reg;
        unread_next = unread_reg;
        ev          = 1'b0;
        armed_now   = armed_reg | start_edge;
        if (command == CMD_READ) begin
            unread_next = 1'b0;
        end else if (armed_now) begin
            armed_next = 1'b1;
            if (wait_reg > WAIT_W'(1)) begin
                wait_next = wait_reg - WAIT_W'(1);
            end else if (pos_reg == IDLE_POS) begin
                // Start sample: high is noise, low opens the frame
                if (ir_sample) begin
                    armed_next = 1'b0;
                    wait_next  = cfg.wait_initial;
                end else begin
                    wait_next  = cfg.wait_half_bit;
                    pos_next   = '0;
                    shift_next = '0;
                end
            end else if (pos_reg < LAST_POS) begin
                shift_next = {shift_reg[FRAME_BITS-2:0], ir_sample};
                wait_next  = cfg.wait_full_bit;
                pos_next   = pos_reg + POS_W'(1);
            end else begin
                // Close the frame, latch it when it differs
                armed_next = 1'b0;
                pos_next   = IDLE_POS;
                wait_next  = cfg.wait_after_frame;
                if (stored_reg != shift_reg) begin
                    stored_next = shift_reg;
                    unread_next = 1'b1;
                    ev          = 1'b1;
                end
            end
        end
    end

    // Hold frame state, advance on each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg  <= 1'b0;
            wait_reg   <= '0;
            pos_reg    <= IDLE_POS;
            shift_reg  <= '0;
            stored_reg <= '0;
            unread_reg <= 1'b0;
        end else if (step) begin
            armed_reg  <= armed_next;
            wait_reg   <= wait_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            stored_reg <= stored_next;
            unread_reg <= unread_next;
        end
    end

    // Result fields from the state after this item
    assign vis                = visible_bits(stored_next);
    assign res.event_valid    = ev;
    assign res.event_code     = ev ? vis[CODE_W-1:0] : '0;
    assign res.new_data       = unread_next;
    assign res.toggle_bit     = vis[VIS_BITS-1];
    assign res.device_address = vis[VIS_BITS-2:CODE_W];
    assign res.data_bits      = vis[CODE_W-1:0];

endmodule

[src/rc5_ir_frame_sampler.sv]
// RC-5 infrared frame sampler. Each input transaction is either a sampling
// tick (s_tuser = 0) carrying the receiver line level and a start-edge flag,
// or a read (s_tuser = 1) that clears the new-data flag. Every input
// transaction yields exactly one result transaction with the stored frame
// fields; m_tuser marks a newly latched distinct frame whose command bits are
// in the event code. Items pass an input register, one level of frame logic
// and an output register: one item per clock sustained while m_tready is high,
// with the input register taking a new item while a result waits, if it is
// empty. Wait registers are written through the cfg_* channel, which is
// always ready; write them only while no items are in flight.
module rc5_ir_frame_sampler
    import rc5_ir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,  // [0] ir_sample, [1] start_edge, [7:2] zero
    input  logic                 s_tuser,  // [0] command
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,  // [5:0] event_code, [6] new_data, [7] toggle_bit,
                                           // [12:8] device_address, [18:13] data_bits,
                                           // [23:19] zero
    output logic                 m_tuser,  // [0] event_valid
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WAIT_W-1:0]    cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t out_reg;
    logic out_valid_reg;
    logic in_valid_reg;
    logic in_cmd_reg;
    logic in_level_reg;
    logic in_edge_reg;
    logic advance;
    logic step;

    assign cfg_ready = 1'b1;

    rc5_ir_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline moves when the output slot is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    rc5_ir_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .command    (in_cmd_reg),
        .ir_sample  (in_level_reg),
        .start_edge (in_edge_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser;
            in_level_reg <= s_tdata[0];
            in_edge_reg  <= s_tdata[1];
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_valid;
    assign m_tdata  = {5'd0, out_reg.data_bits, out_reg.device_address,
                       out_reg.toggle_bit, out_reg.new_data, out_reg.event_code};

endmodule

[src/rc5_ir_checker.sv]
module rc5_ir_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser
);

    // A stalled result holds its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A new frame event always leaves the new-data flag set
    a_event_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[6])
        else $error("event without new-data flag");

    // Event code matches the command bits of the stored frame
    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[5:0] == m_tdata[18:13])
        else $error("event code differs from stored frame");

    // No event means a zero event code
    a_idle_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[5:0] == 6'd0)
        else $error("event code set without event");

endmodule

bind rc5_ir_frame_sampler rc5_ir_checker u_rc5_ir_checker (.*);

[test/testbench.sv]
module testbench;
    import rc5_ir_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [0] ir_sample, [1] start_edge, [7:2] zero
    logic                 s_tuser;   // [0] command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [5:0] event_code, [6] new_data, [7] toggle_bit,
                                     // [12:8] device_address, [18:13] data_bits
    logic                 m_tuser;   // [0] event_valid
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WAIT_W-1:0]    cfg_data;

    rc5_ir_frame_sampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mirror of the sampler: wait registers and frame state
    logic [WAIT_W-1:0]     cfg_init, cfg_half, cfg_full, cfg_after;
    logic                  armed;
    logic [WAIT_W-1:0]     wait_left;
    logic [POS_W-1:0]      bit_pos;
    logic [FRAME_BITS-1:0] shift_bits;
    logic [FRAME_BITS-1:0] held_frame;
    logic                  unread;

    res_t pending_reports [$];
    int   fail_cnt       = 0;
    int   items_sent     = 0;
    int   frames_latched = 0;
    int   noise_starts   = 0;
    int   config_sets    = 0;
    bit   calm           = 1'b0;  // no idling on either side
    bit   burst          = 1'b0;  // back-to-back ticks while draining a long wait

    // Opening sequence, run with every wait register at one
    typedef struct {
        logic kind;
        logic lvl;
        logic start_edge;
        int   reps;
        bit   typed;
        res_t res;
    } step_row_t;

    localparam res_t RES_CLEAR      = '0;
    // event_valid, event_code, new_data, toggle_bit, device_address, data_bits
    localparam res_t RES_ONES_EVENT = '{1'b1, 6'h3f, 1'b1, 1'b1, 5'h1f, 6'h3f};
    localparam res_t RES_ONES_HELD  = '{1'b0, 6'h00, 1'b0, 1'b1, 5'h1f, 6'h3f};

    step_row_t opening_rows [10] = '{
        // start edge on a read is ignored
        '{CMD_READ, 1'b1, 1'b1, 1,  1'b1, RES_CLEAR},
        // tick while disarmed
        '{CMD_TICK, 1'b1, 1'b0, 1,  1'b1, RES_CLEAR},
        // high first sample is noise
        '{CMD_TICK, 1'b1, 1'b1, 1,  1'b1, RES_CLEAR},
        // low first sample starts a frame
        '{CMD_TICK, 1'b0, 1'b1, 1,  1'b0, RES_CLEAR},
        // all-zero bits, start edge while armed
        '{CMD_TICK, 1'b0, 1'b1, 12, 1'b0, RES_CLEAR},
        // close: same as the stored frame, no event
        '{CMD_TICK, 1'b1, 1'b0, 1,  1'b1, RES_CLEAR},
        '{CMD_TICK, 1'b0, 1'b1, 1,  1'b0, RES_CLEAR},
        '{CMD_TICK, 1'b1, 1'b0, 12, 1'b0, RES_CLEAR},
        // close: all-ones frame is latched
        '{CMD_TICK, 1'b0, 1'b0, 1,  1'b1, RES_ONES_EVENT},
        // read clears the new-data flag
        '{CMD_READ, 1'b0, 1'b0, 1,  1'b1, RES_ONES_HELD}
    };

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Advance the frame state by one transaction and return the report it yields
    function automatic res_t advance_sampler(input logic kind, input logic lvl,
                                             input logic start_edge);
        res_t rep;
        logic latched;
        latched = 1'b0;
        if (kind == CMD_READ) begin
            unread = 1'b0;
        end else begin
            if (start_edge) armed = 1'b1;
            if (armed) begin
                if (wait_left > 1) begin
                    wait_left = wait_left - 1'b1;
                end else if (bit_pos == IDLE_POS) begin
                    if (lvl) begin
                        armed     = 1'b0;
                        wait_left = cfg_init;
                    end else begin
                        wait_left  = cfg_half;
                        bit_pos    = '0;
                        shift_bits = '0;
                    end
                end else if (bit_pos < LAST_POS) begin
                    shift_bits = {shift_bits[FRAME_BITS-2:0], lvl};
                    wait_left  = cfg_full;
                    bit_pos    = bit_pos + 1'b1;
                end else begin
                    armed     = 1'b0;
                    bit_pos   = IDLE_POS;
                    wait_left = cfg_after;
                    if (held_frame != shift_bits) begin
                        held_frame = shift_bits;
                        unread     = 1'b1;
                        latched    = 1'b1;
                    end
                end
            end
        end
        rep.event_valid    = latched;
        rep.event_code     = latched ? held_frame[5:0] : '0;
        rep.new_data       = unread;
        rep.toggle_bit     = held_frame[11];
        rep.device_address = held_frame[10:6];
        rep.data_bits      = held_frame[5:0];
        return rep;
    endfunction

    // Offer one transaction after a random gap; record its report once accepted
    task automatic send_item(input logic kind, input logic lvl, input logic start_edge,
                             input bit typed = 1'b0, input res_t want = '0);
        int   gap;
        res_t rep;
        gap = (calm || burst) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, start_edge, lvl};
        do @(posedge aclk); while (!s_tready);
        rep = advance_sampler(kind, lvl, start_edge);
        pending_reports.push_back(typed ? want : rep);
        items_sent++;
        if (rep.event_valid) frames_latched++;
    endtask

    // Hold the input side until every report is back and the pipeline is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WAIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_WAIT_INITIAL:     cfg_init  = val;
            REG_WAIT_HALF_BIT:    cfg_half  = val;
            REG_WAIT_FULL_BIT:    cfg_full  = val;
            REG_WAIT_AFTER_FRAME: cfg_after = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [WAIT_W-1:0] w_init, input logic [WAIT_W-1:0] w_half,
                                input logic [WAIT_W-1:0] w_full, input logic [WAIT_W-1:0] w_after);
        wait_drained();
        write_reg(REG_WAIT_INITIAL, w_init);
        write_reg(REG_WAIT_HALF_BIT, w_half);
        write_reg(REG_WAIT_FULL_BIT, w_full);
        write_reg(REG_WAIT_AFTER_FRAME, w_after);
        cfg_valid <= 1'b0;
        config_sets++;
    endtask

    // Frame content: often a repeat of the stored frame, sometimes all zeros or ones
    function automatic logic [FRAME_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1:    return held_frame;
            2:       return '0;
            3:       return {FRAME_BITS{1'b1}};
            default: return FRAME_BITS'($urandom);
        endcase
    endfunction

    // Drive a well-formed frame: correct levels at each sampling point, noise elsewhere
    task automatic run_frame(input logic [FRAME_BITS-1:0] word);
        logic lvl;
        logic start_edge;
        bit   closing;
        bit   done;
        done = 1'b0;
        while (!done) begin
            if ($urandom_range(0, 9) == 0) send_item(CMD_READ, coin(), coin());
            start_edge = armed ? coin() : 1'b1;
            closing    = (bit_pos == LAST_POS) && (wait_left <= 1);
            if (wait_left > 1 || closing)
                lvl = coin();
            else if (bit_pos == IDLE_POS)
                lvl = 1'b0;
            else
                lvl = word[FRAME_BITS-1-int'(bit_pos)];
            send_item(CMD_TICK, lvl, start_edge);
            done = closing;
        end
    endtask

    // Arm and present a high level at the first sampling point
    task automatic run_noise();
        bit at_sample;
        bit done;
        if (bit_pos != IDLE_POS) run_frame(pick_word());
        done = 1'b0;
        while (!done) begin
            at_sample = (wait_left <= 1);
            send_item(CMD_TICK, at_sample ? 1'b1 : coin(), armed ? coin() : 1'b1);
            done = at_sample;
        end
        noise_starts++;
    endtask

    task automatic run_junk(input int count);
        for (int n = 0; n < count; n++)
            send_item(($urandom_range(0, 3) == 0) ? CMD_READ : CMD_TICK, coin(), coin());
    endtask

    // Count a long wait down with back-to-back ticks
    task automatic drain_wait();
        burst = 1'b1;
        while (wait_left > 1) send_item(CMD_TICK, coin(), 1'b1);
        burst = 1'b0;
    endtask

    task automatic run_phase(input int quota);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < quota) begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                run_frame(pick_word());
            else if (pick == 7)
                run_noise();
            else
                run_junk($urandom_range(1, 8));
        end
        calm = 1'b0;
    endtask

    // Compare one report field and log a mismatch
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Match each result transaction against the oldest pending report
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tuser %0b tdata %h",
                         $time, m_tuser, m_tdata);
                fail_cnt++;
            end else begin
                want = pending_reports.pop_front();
                check_field("event_valid", want.event_valid, m_tuser);
                check_field("event_code", want.event_code, m_tdata[5:0]);
                check_field("new_data", want.new_data, m_tdata[6]);
                check_field("toggle_bit", want.toggle_bit, m_tdata[7]);
                check_field("device_address", want.device_address, m_tdata[12:8]);
                check_field("data_bits", want.data_bits, m_tdata[18:13]);
            end
        end
    end

    // Result side: random stall before each transaction
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = (calm || burst) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #4000000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_TICK;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WAIT_INITIAL;
        cfg_data  <= '0;

        cfg_init   = RST_WAIT_INITIAL;
        cfg_half   = RST_WAIT_HALF_BIT;
        cfg_full   = RST_WAIT_FULL_BIT;
        cfg_after  = RST_WAIT_AFTER_FRAME;
        armed      = 1'b0;
        wait_left  = '0;
        bit_pos    = IDLE_POS;
        shift_bits = '0;
        held_frame = '0;
        unread     = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Opening table with the shortest waits
        write_config(16'd1, 16'd1, 16'd1, 16'd1);
        foreach (opening_rows[r])
            for (int n = 0; n < opening_rows[r].reps; n++)
                send_item(opening_rows[r].kind, opening_rows[r].lvl, opening_rows[r].start_edge,
                          opening_rows[r].typed, opening_rows[r].res);

        write_config(16'd3, 16'd2, 16'd3, 16'd5);
        run_phase(350);

        write_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
        run_phase(350);

        write_config(RST_WAIT_INITIAL, RST_WAIT_HALF_BIT, RST_WAIT_FULL_BIT,
                     RST_WAIT_AFTER_FRAME);
        run_phase(350);

        // Long waits: count down both the after-frame and the noise reload
        write_config(16'd150, 16'd1, 16'd1, 16'd150);
        run_frame(pick_word());
        drain_wait();
        run_noise();
        drain_wait();

        write_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
        run_phase(350);

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d transactions over %0d wait settings (one to 150 ticks)",
                 items_sent, config_sets);
        $display("latched %0d distinct frames, drove %0d noise starts", frames_latched,
                 noise_starts);
        if (fail_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
